/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file aes_cbc_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("check failed");
`endif

/* hw/rtl/aes_pkg.sv */
package aes_pkg;
    localparam int BlockBytes = 16;
    localparam int RkDepth = 60;
    localparam int RkAw = 6;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ENC = 1'b1;
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_KSEL = 3'd4;

    typedef struct packed {
        logic        op;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_req;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_out_req;

    typedef struct packed {
        logic [2:0]  index;
        logic [63:0] data;
    } t_cfg_req;

    typedef struct packed {
        logic            we;
        logic [RkAw-1:0] waddr;
        logic [31:0]     wdata;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) t[4*c+k] = b[4*((c+k)%4)+k];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (last) begin
                r[127-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                r[127-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                     a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        aes_round = r;
    endfunction
endpackage

/* hw/rtl/aes_if.sv */
interface aes_in_if;
    import aes_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aes_out_if;
    import aes_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aes_cfg_if;
    import aes_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/aes_keyexp.sv */
module aes_keyexp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [255:0]    i_key,
    input  logic [1:0]      i_sel,
    output logic            o_busy,
    output aes_pkg::t_rk_wr o_wr
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN} t_state;

    t_state         r_state, n_state;
    logic [RkAw-1:0] r_i, n_i;
    logic [7:0]     r_rcon, n_rcon;
    logic [31:0]    r_win [8];
    logic [31:0]    n_word;
    logic [2:0]     r_ph, n_ph;
    logic [3:0]     nk;
    logic [RkAw-1:0] total;
    logic [31:0]    t;

    always_comb begin
        case (i_sel)
            2'd0: begin nk = 4'd4; total = 6'd43; end
            2'd1: begin nk = 4'd6; total = 6'd51; end
            default: begin nk = 4'd8; total = 6'd59; end
        endcase
    end

    always_comb begin
        t = r_win[0];
        if (r_ph == 3'd0) begin
            t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_ph == 3'd4) begin
            t = sub_word(r_win[0]);
        end
        n_word = r_win[3'(nk - 4'd1)] ^ t;
        n_state = r_state;
        n_i = r_i;
        n_rcon = r_rcon;
        n_ph = r_ph;
        o_wr.we = 1'b0;
        o_wr.waddr = r_i;
        o_wr.wdata = n_word;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_LOAD;
                    n_i = '0;
                end
            end
            S_LOAD: begin
                o_wr.we = 1'b1;
                o_wr.wdata = i_key[255 - 32*r_i[2:0] -: 32];
                n_i = r_i + 6'd1;
                if (r_i == RkAw'(nk - 4'd1)) begin
                    n_state = S_RUN;
                    n_rcon = 8'h01;
                    n_ph = 3'd0;
                end
            end
            S_RUN: begin
                o_wr.we = 1'b1;
                n_i = r_i + 6'd1;
                n_ph = (r_ph == 3'(nk - 4'd1)) ? 3'd0 : r_ph + 3'd1;
                if (r_ph == 3'd0) n_rcon = xtime(r_rcon);
                if (r_i == total) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The window holds the last nk words, newest in slot 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i <= '0;
            r_rcon <= 8'h01;
            r_ph <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_rcon <= n_rcon;
            r_ph <= n_ph;
        end
        if (o_wr.we) begin
            for (int k = 7; k > 0; k--) r_win[k] <= r_win[k-1];
            r_win[0] <= o_wr.wdata;
        end
    end

    assign o_busy = (r_state != S_IDLE) || i_start;
endmodule

/* hw/rtl/aes_core.sv */
module aes_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aes_pkg::t_rk_wr i_wr,
    input  logic            i_kbusy,
    input  logic [1:0]      i_sel,
    aes_in_if.sink          s_in,
    aes_out_if.source       m_out
);
    import aes_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_state;

    logic [31:0]     r_mem [RkDepth];
    logic [31:0]     r_rd;
    logic [RkAw-1:0] rd_addr;
    t_state          r_state;
    logic [RkAw-1:0] r_addr;
    logic [1:0]      r_col;
    logic [3:0]      r_rnd;
    logic [127:0]    r_s, r_acc, r_chain;
    logic [127:0]    r_out;
    logic [3:0]      nr;
    logic            take;

    always_comb begin
        case (i_sel)
            2'd0: nr = 4'd10;
            2'd1: nr = 4'd12;
            default: nr = 4'd14;
        endcase
    end

    assign s_in.ready = (r_state == S_IDLE) && !i_kbusy;
    assign take = s_in.valid && s_in.ready;
    assign rd_addr = take ? '0 : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[i_wr.waddr] <= i_wr.wdata;
        r_rd <= r_mem[rd_addr];
    end

    // One round key word per cycle; four words make a round.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= '0;
            r_addr <= '0;
            r_col <= '0;
            r_rnd <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (s_in.data.op == OP_LOAD) begin
                            r_chain <= {s_in.data.block_high, s_in.data.block_low};
                        end else begin
                            r_state <= S_RUN;
                            r_s <= {s_in.data.block_high, s_in.data.block_low} ^ r_chain;
                            r_addr <= 6'd1;
                            r_col <= '0;
                            r_rnd <= '0;
                        end
                    end
                end
                S_RUN: begin
                    r_acc[127 - 32*r_col -: 32] <= r_rd;
                    r_addr <= r_addr + 6'd1;
                    r_col <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        if (r_rnd == 4'd0) begin
                            r_s <= r_s ^ {r_acc[127:32], r_rd};
                        end else begin
                            r_s <= aes_round(r_s, r_rnd == nr) ^ {r_acc[127:32], r_rd};
                        end
                        r_rnd <= r_rnd + 4'd1;
                        if (r_rnd == nr) begin
                            r_state <= S_OUT;
                            r_chain <= aes_round(r_s, 1'b1) ^ {r_acc[127:32], r_rd};
                            r_out <= aes_round(r_s, 1'b1) ^ {r_acc[127:32], r_rd};
                        end
                    end
                end
                S_OUT: begin
                    if (m_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid = (r_state == S_OUT);
    assign m_out.data.cipher_high = r_out[127:64];
    assign m_out.data.cipher_low = r_out[63:0];
endmodule

/* hw/rtl/aes_cbc_encrypt.sv */
// An encrypt request reads 4*(Nr+1) round key words (44, 52 or 60), one per cycle
// from the key memory, before its result; a load request only sets the chaining value.
// One encrypt at a time: no request is accepted while a result waits; the next one is
// accepted in the cycle after the result is taken unless key expansion or a config write holds it.
// Reset (synchronous, active low) clears the chaining value and expands the
// all-zero 128-bit key; key and key-size writes re-expand the key, holding off requests.
module aes_cbc_encrypt (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aes_cfg_if.sink   s_cfg,
    aes_in_if.sink    s_in,
    aes_out_if.source m_out
);
    import aes_pkg::*;

    logic [63:0] r_key [4];
    logic [1:0]  r_sel;
    logic        r_start;
    logic        kbusy;
    t_rk_wr      wr;

    assign s_cfg.ready = !kbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_sel <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (s_cfg.valid && s_cfg.ready) begin
                if (s_cfg.data.index <= REG_KEY3) begin
                    r_key[s_cfg.data.index[1:0]] <= s_cfg.data.data;
                    r_start <= 1'b1;
                end else if (s_cfg.data.index == REG_KSEL) begin
                    r_sel <= (s_cfg.data.data[1:0] == 2'd3) ? 2'd2 : s_cfg.data.data[1:0];
                    r_start <= 1'b1;
                end
            end
        end
    end

    aes_keyexp u_kexp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_key  ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_sel  (r_sel),
        .o_busy (kbusy),
        .o_wr   (wr)
    );

    aes_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (wr),
        .i_kbusy(kbusy || s_cfg.valid),
        .i_sel  (r_sel),
        .s_in   (s_in),
        .m_out  (m_out)
    );
endmodule

/* hw/rtl/aes_cbc_check.sv */
`include "assert_macros.svh"
module aes_cbc_check (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input logic [127:0] out_data
);
    `CHK_IMPLY(a_no_take_busy, i_clk, i_rst_n, out_valid, !in_ready)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `CHK_NEXT(a_out_after, i_clk, i_rst_n, in_valid && in_ready, !out_valid)
endmodule

bind aes_cbc_encrypt aes_cbc_check u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (s_in.valid),
    .in_ready (s_in.ready),
    .out_valid(m_out.valid),
    .out_ready(m_out.ready),
    .out_data ({m_out.data.cipher_high, m_out.data.cipher_low})
);

/* test/aes_cbc_checker.sv */
module aes_cbc_checker
    import aes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_fire,
    input  t_cfg_req i_cfg,
    input  logic     i_in_fire,
    input  t_in_req  i_in,
    input  logic     i_out_fire,
    input  t_out_req i_out,
    output int       o_errors,
    output int       o_pending
);
    logic [63:0]  key_regs [4];
    logic [1:0]   key_sel;
    logic [127:0] chain;
    logic [31:0]  sched [60];
    int           rounds;
    t_out_req     cipher_q [$];

    function automatic logic [7:0] dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    task automatic expand_schedule();
        int nk;
        int total;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (key_sel == 2'd0) ? 4 : (key_sel == 2'd1) ? 6 : 8;
        rounds = nk + 6;
        total = 4 * (rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = (i % 2) ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endtask

    function automatic logic [127:0] cipher_block(input logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ sched[i / 4][31 - 8 * (i % 4) -: 8];
        for (int rnd = 1; rnd <= rounds; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++) t[4 * c + k] = SBOX[s[4 * ((c + k) % 4) + k]];
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                if (rnd != rounds) begin
                    al = a0 ^ a1 ^ a2 ^ a3;
                    a0 = t[4 * c] ^ al ^ dbl(t[4 * c] ^ t[4 * c + 1]);
                    a1 = t[4 * c + 1] ^ al ^ dbl(t[4 * c + 1] ^ t[4 * c + 2]);
                    a2 = t[4 * c + 2] ^ al ^ dbl(t[4 * c + 2] ^ t[4 * c + 3]);
                    a3 = t[4 * c + 3] ^ al ^ dbl(t[4 * c + 3] ^ t[4 * c]);
                end
                s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
            end
            for (int i = 0; i < 16; i++)
                s[i] = s[i] ^ sched[rnd * 4 + i / 4][31 - 8 * (i % 4) -: 8];
        end
        for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        o_errors++;
    endtask

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_regs[i] = '0;
            key_sel = '0;
            chain = '0;
            cipher_q.delete();
            expand_schedule();
        end else begin
            if (i_cfg_fire) begin
                if (i_cfg.index <= REG_KEY3) begin
                    key_regs[i_cfg.index[1:0]] = i_cfg.data;
                    expand_schedule();
                end else if (i_cfg.index == REG_KSEL) begin
                    key_sel = (i_cfg.data[1:0] == 2'd3) ? 2'd2 : i_cfg.data[1:0];
                    expand_schedule();
                end
            end
            if (i_in_fire) begin
                if (i_in.op == OP_LOAD) begin
                    chain = {i_in.block_high, i_in.block_low};
                end else begin
                    chain = cipher_block(chain ^ {i_in.block_high, i_in.block_low});
                    cipher_q.push_back(chain);
                end
            end
            if (i_out_fire) begin
                if (cipher_q.size() == 0) begin
                    report("unexpected result", i_out.cipher_high, '0);
                end else begin
                    want = cipher_q.pop_front();
                    if (i_out.cipher_high !== want.cipher_high)
                        report("cipher_high", i_out.cipher_high, want.cipher_high);
                    if (i_out.cipher_low !== want.cipher_low)
                        report("cipher_low", i_out.cipher_low, want.cipher_low);
                end
            end
        end
    end
endmodule

/* test/tb.sv */
module tb;
    import aes_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    logic hold_off = 1'b0;

    aes_cfg_if cfg_ch ();
    aes_in_if  in_ch ();
    aes_out_if out_ch ();

    aes_cbc_encrypt i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_cfg   (cfg_ch.sink),
        .s_in    (in_ch.sink),
        .m_out   (out_ch.source)
    );

    aes_cbc_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_fire (cfg_ch.valid && cfg_ch.ready),
        .i_cfg      (cfg_ch.data),
        .i_in_fire  (in_ch.valid && in_ch.ready),
        .i_in       (in_ch.data),
        .i_out_fire (out_ch.valid && out_ch.ready),
        .i_out      (out_ch.data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off && !held) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                held = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_ch.data <= '{index: idx, data: val};
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        repeat (70) @(posedge i_clk);
    endtask

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                              input bit no_gap);
        int g;
        in_ch.data <= '{op: op, block_high: hi, block_low: lo};
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        g = gap_len();
        if (!no_gap && g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_key(input logic [1:0] sel);
        for (int i = 0; i <= REG_KEY3; i++) write_reg(i[2:0], rand64());
        write_reg(REG_KSEL, {62'h0, sel});
    endtask

    initial begin
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (70) @(posedge i_clk);

        send_block(OP_ENC, '0, '0, 1'b0);
        send_block(OP_ENC, '1, '1, 1'b0);
        send_block(OP_LOAD, '1, '1, 1'b0);
        send_block(OP_ENC, '0, '0, 1'b0);
        drain();
        write_reg(REG_KEY0, 64'h0001020304050607);
        write_reg(REG_KEY0 + 3'd1, 64'h08090a0b0c0d0e0f);
        send_block(OP_LOAD, '0, '0, 1'b0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        drain();
        write_reg(REG_KEY0 + 3'd2, 64'h1011121314151617);
        write_reg(REG_KSEL, 64'd1);
        send_block(OP_LOAD, '0, '0, 1'b0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        drain();
        write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
        write_reg(REG_KSEL, 64'd2);
        send_block(OP_LOAD, '0, '0, 1'b0);
        send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block(OP_ENC, '1, '0, 1'b0);
        drain();
        write_reg(REG_KSEL, 64'd3);
        write_reg(3'd5, '1);
        write_reg(3'd7, 64'h1234);
        send_block(OP_ENC, '0, '1, 1'b0);
        drain();
        write_reg(REG_KSEL, 64'd0);
        write_reg(REG_KEY3, '1);
        send_block(OP_ENC, 64'h8000000000000001, 64'h8000000000000001, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            random_key((phase == 7) ? 2'd3 : phase[1:0] % 3);
            if (phase == 2) hold_off = 1'b1;
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_block(OP_LOAD, rand64(), rand64(), phase == 2);
                else
                    send_block(OP_ENC, rand64(), rand64(), phase == 2);
                if (n == 30) drain();
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: errors");
        $finish;
    end
endmodule
